// ----- rtl/ato_pkg.sv -----
package ato_pkg;

  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  // CORDIC datapath: angles in signed Q4.60 radians, magnitudes normalized to bit 60
  localparam int unsigned FRAC     = 60;
  localparam int unsigned ITERS    = 60;
  localparam int unsigned ZW       = 64;
  localparam int unsigned SHW      = 6;
  localparam int unsigned OCT_MAX  = 44;
  localparam int unsigned OCT_W    = 6;
  localparam int unsigned QDEG_W   = 7;
  localparam int unsigned ANGLE_W  = 9;
  localparam int unsigned ORI_W    = 2;

  localparam logic [QDEG_W-1:0] QDEG_EQUAL = QDEG_W'(45);
  localparam logic [QDEG_W-1:0] QDEG_TOP   = QDEG_W'(89);

  localparam logic [ANGLE_W-1:0] DEG_45  = ANGLE_W'(45);
  localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0] DEG_135 = ANGLE_W'(135);
  localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0] DEG_225 = ANGLE_W'(225);
  localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
  localparam logic [ANGLE_W-1:0] DEG_315 = ANGLE_W'(315);

  // Machin's formula terms atan(1/5) and atan(1/239): first series term and n squared
  localparam logic [ZW-1:0] MACHIN_A_P0 = (ZW'(1) << FRAC) / ZW'(5);
  localparam logic [ZW-1:0] MACHIN_B_P0 = (ZW'(1) << FRAC) / ZW'(239);
  localparam logic [ZW-1:0] MACHIN_A_SQ = ZW'(25);
  localparam logic [ZW-1:0] MACHIN_B_SQ = ZW'(57121);

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_e;

  typedef enum logic [ORI_W-1:0] {
    ORI_UP    = 2'd0,
    ORI_RIGHT = 2'd1,
    ORI_DOWN  = 2'd2,
    ORI_LEFT  = 2'd3
  } ori_e;

  // Per-sample control that rides alongside the CORDIC data
  typedef struct packed {
    logic  undef;
    quad_e quad;
    logic  is_zero;
    logic  is_eq;
    logic  rev;
  } side_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_deg;
    logic [ORI_W-1:0]   orientation;
    logic               direction_undefined;
  } res_t;

  // atan(1/5) or atan(1/239) as an alternating series truncated at Q.FRAC
  function automatic logic [ZW-1:0] atan_recip(logic use_b);
    logic [ZW-1:0] p;
    logic [ZW-1:0] sum;
    logic [ZW-1:0] t;
    logic          done;
    p    = use_b ? MACHIN_B_P0 : MACHIN_A_P0;
    sum  = p;
    done = 1'b0;
    for (int k = 1; k < 64; k++) begin
      if (!done) begin
        p = use_b ? (p / MACHIN_B_SQ) : (p / MACHIN_A_SQ);
        if (p == '0) begin
          done = 1'b1;
        end else begin
          t = p / ZW'(2 * k + 1);
          if ((k & 1) != 0) sum = sum - t;
          else sum = sum + t;
        end
      end
    end
    return sum;
  endfunction

  // pi/4 by Machin's formula
  function automatic logic [ZW-1:0] pi_quarter();
    return (atan_recip(1'b0) << 2) - atan_recip(1'b1);
  endfunction

  // atan(2^-i) for i >= 1 as a truncated series
  function automatic logic [ZW-1:0] atan_pow2(int unsigned i);
    logic [ZW-1:0] sum;
    logic [ZW-1:0] t;
    int unsigned   e;
    logic          done;
    sum  = '0;
    done = 1'b0;
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e > FRAC) done = 1'b1;
      if (!done) begin
        t = (ZW'(1) << (FRAC - e)) / ZW'(2 * k + 1);
        if ((k & 1) != 0) sum = sum - t;
        else sum = sum + t;
      end
    end
    return sum;
  endfunction

  function automatic logic [ZW-1:0] atan_entry(int unsigned i);
    return (i == 0) ? pi_quarter() : atan_pow2(i);
  endfunction

  localparam logic [ZW-1:0] PI_QUARTER = pi_quarter();
  localparam logic [ZW-1:0] DEG_UNIT   = PI_QUARTER / 45;

endpackage

// ----- rtl/ato_sample_if.sv -----
interface ato_sample_if #(
  parameter int unsigned SAMPLE_WIDTH = ato_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;

  modport source (output valid, output accel_x, output accel_y, input ready);
  modport sink   (input valid, input accel_x, input accel_y, output ready);
endinterface

// ----- rtl/ato_result_if.sv -----
interface ato_result_if;
  logic                             valid;
  logic                             ready;
  logic [ato_pkg::ANGLE_W-1:0]      angle_deg;
  logic [ato_pkg::ORI_W-1:0]        orientation;
  logic                             direction_undefined;

  modport source (output valid, output angle_deg, output orientation,
                  output direction_undefined, input ready);
  modport sink   (input valid, input angle_deg, input orientation,
                  input direction_undefined, output ready);
endinterface

// ----- rtl/accel_tilt_orientation.sv -----
// Channel    Dir  Fields                                                       Handshake
// sample_i   in   accel_x, accel_y (SAMPLE_WIDTH, signed)                      valid/ready
// result_o   out  angle_deg (9), orientation (2), direction_undefined (1)      valid/ready
//
// One sample enters per cycle while the skid register is empty; each result
// passes through front-end reduction, the 60-stage unrolled vectoring CORDIC
// and back-end degree decode. Reset clears only valid bits.
// A stalled result parks in a skid register; the pipeline freezes only while
// that skid register is full, so sample_i.ready is a registered signal.
module accel_tilt_orientation #(
  parameter int unsigned SAMPLE_WIDTH = ato_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ato_sample_if.sink    sample_i,
  ato_result_if.source  result_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned LW    = $clog2(SW);
  localparam int unsigned ZW    = ato_pkg::ZW;
  localparam int unsigned ITERS = ato_pkg::ITERS;
  localparam int unsigned SHW   = ato_pkg::SHW;
  localparam int unsigned OMAX  = ato_pkg::OCT_MAX;
  localparam int unsigned OW    = ato_pkg::OCT_W;
  localparam int unsigned QW    = ato_pkg::QDEG_W;
  localparam int unsigned AW    = ato_pkg::ANGLE_W;

  logic en;
  logic skid_valid_q, skid_valid_d;
  logic out_valid_q, out_valid_d;
  ato_pkg::res_t skid_q, skid_d;
  ato_pkg::res_t out_q, out_d;

  // Whole pipeline advances unless a result is parked in the skid register
  assign en             = !skid_valid_q;
  assign sample_i.ready = en;

  // ---------------- stage 1: capture sample ----------------
  logic          s1_valid_q;
  logic [SW-1:0] s1_x_q, s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_x_q <= sample_i.accel_x;
      s1_y_q <= sample_i.accel_y;
    end
  end

  // ---------------- stage 2: quadrant and octant reduction ----------------
  logic          xneg, yneg;
  logic [SW-1:0] ax, ay, qa, qb;
  ato_pkg::side_t s2_side_d;
  logic [SW-1:0] s2_n_d, s2_m_d;

  assign xneg = s1_x_q[SW-1];
  assign yneg = s1_y_q[SW-1];
  assign ax   = xneg ? SW'(~s1_x_q + 1'b1) : s1_x_q;
  assign ay   = yneg ? SW'(~s1_y_q + 1'b1) : s1_y_q;

  always_comb begin
    s2_side_d.undef = (ax == '0) && (ay == '0);
    priority if (!xneg && !yneg && ay != '0) begin
      s2_side_d.quad = ato_pkg::QUAD_0;
      qa = ax;
      qb = ay;
    end else if (!xneg && ax != '0) begin
      s2_side_d.quad = ato_pkg::QUAD_90;
      qa = ay;
      qb = ax;
    end else if (yneg) begin
      s2_side_d.quad = ato_pkg::QUAD_180;
      qa = ax;
      qb = ay;
    end else begin
      s2_side_d.quad = ato_pkg::QUAD_270;
      qa = ay;
      qb = ax;
    end
    s2_side_d.is_zero = (qa == '0);
    s2_side_d.is_eq   = (qa == qb);
    // Above the diagonal: measure the complement angle and mirror it later
    s2_side_d.rev     = (qa > qb);
    s2_n_d = s2_side_d.rev ? qb : qa;
    s2_m_d = s2_side_d.rev ? qa : qb;
  end

  logic           s2_valid_q;
  ato_pkg::side_t s2_side_q;
  logic [SW-1:0]  s2_n_q, s2_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_side_q <= s2_side_d;
      s2_n_q    <= s2_n_d;
      s2_m_q    <= s2_m_d;
    end
  end

  // ---------------- stage 3: leading-one search ----------------
  logic [LW-1:0] lead;

  always_comb begin
    lead = '0;
    for (int i = 0; i < SW; i++) begin
      if (s2_m_q[i]) lead = LW'(i);
    end
  end

  logic           s3_valid_q;
  ato_pkg::side_t s3_side_q;
  logic [SW-1:0]  s3_n_q, s3_m_q;
  logic [SHW-1:0] s3_sh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= s2_side_q;
      s3_n_q    <= s2_n_q;
      s3_m_q    <= s2_m_q;
      s3_sh_q   <= SHW'(ato_pkg::FRAC) - SHW'(lead);
    end
  end

  // ---------------- CORDIC stages ----------------
  logic [ZW-1:0]  cx_q [ITERS+1];
  logic [ZW-1:0]  cy_q [ITERS+1];
  logic [ZW-1:0]  cz_q [ITERS+1];
  logic           cv_q [ITERS+1];
  ato_pkg::side_t cs_q [ITERS+1];

  // Normalize so the larger magnitude's top bit sits at bit FRAC
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0] <= ZW'(s3_m_q) << s3_sh_q;
      cy_q[0] <= ZW'(s3_n_q) << s3_sh_q;
      cz_q[0] <= '0;
      cs_q[0] <= s3_side_q;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam logic [ZW-1:0] ANG = ato_pkg::atan_entry(i);
    logic [ZW-1:0] dx, dy;
    logic          yneg_i;

    assign dx     = $unsigned($signed(cy_q[i]) >>> i);
    assign dy     = cx_q[i] >> i;
    assign yneg_i = cy_q[i][ZW-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (en) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cs_q[i+1] <= cs_q[i];
        if (!yneg_i) begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + ANG;
        end else begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - ANG;
        end
      end
    end
  end

  // ---------------- degree thresholds ----------------
  logic [OMAX-1:0] ge_d;

  for (genvar k = 1; k <= OMAX; k++) begin : g_thr
    localparam logic [ZW-1:0] TH = ZW'(k) * ato_pkg::DEG_UNIT;
    // Negative angle counts as zero degrees
    assign ge_d[k-1] = !cz_q[ITERS][ZW-1] && (cz_q[ITERS] >= TH);
  end

  logic            t_valid_q;
  ato_pkg::side_t  t_side_q;
  logic [OMAX-1:0] t_ge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_valid_q <= 1'b0;
    end else if (en) begin
      t_valid_q <= cv_q[ITERS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_side_q <= cs_q[ITERS];
      t_ge_q   <= ge_d;
    end
  end

  // ---------------- thermometer decode ----------------
  logic [OW-1:0] oct_d;

  always_comb begin
    oct_d = '0;
    for (int k = 0; k < OMAX; k++) begin
      if (t_ge_q[k]) oct_d = OW'(k + 1);
    end
  end

  logic           p_valid_q;
  ato_pkg::side_t p_side_q;
  logic [OW-1:0]  p_oct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= t_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_side_q <= t_side_q;
      p_oct_q  <= oct_d;
    end
  end

  // ---------------- angle assembly and orientation ----------------
  logic [QW-1:0] qdeg;
  logic [AW-1:0] base, deg;
  ato_pkg::res_t fin;

  always_comb begin
    priority if (p_side_q.is_zero) qdeg = '0;
    else if (p_side_q.is_eq) qdeg = ato_pkg::QDEG_EQUAL;
    else if (p_side_q.rev) qdeg = ato_pkg::QDEG_TOP - QW'(p_oct_q);
    else qdeg = QW'(p_oct_q);

    unique case (p_side_q.quad)
      ato_pkg::QUAD_0:   base = '0;
      ato_pkg::QUAD_90:  base = ato_pkg::DEG_90;
      ato_pkg::QUAD_180: base = ato_pkg::DEG_180;
      ato_pkg::QUAD_270: base = ato_pkg::DEG_270;
      default:           base = '0;
    endcase
    deg = base + AW'(qdeg);

    if (p_side_q.undef) begin
      fin.angle_deg           = '0;
      fin.orientation         = ato_pkg::ORI_UP;
      fin.direction_undefined = 1'b1;
    end else begin
      fin.angle_deg           = deg;
      fin.direction_undefined = 1'b0;
      // Exact boundary degrees fall through to the upright code
      priority if (deg > ato_pkg::DEG_45 && deg < ato_pkg::DEG_135) begin
        fin.orientation = ato_pkg::ORI_RIGHT;
      end else if (deg > ato_pkg::DEG_135 && deg < ato_pkg::DEG_225) begin
        fin.orientation = ato_pkg::ORI_DOWN;
      end else if (deg > ato_pkg::DEG_225 && deg < ato_pkg::DEG_315) begin
        fin.orientation = ato_pkg::ORI_LEFT;
      end else begin
        fin.orientation = ato_pkg::ORI_UP;
      end
    end
  end

  // ---------------- output register and skid ----------------
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (result_o.ready) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (!out_valid_q || result_o.ready) begin
      out_d       = fin;
      out_valid_d = p_valid_q;
    end else if (p_valid_q) begin
      // Park the beat leaving the pipeline; freeze from next cycle
      skid_d       = fin;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign result_o.valid               = out_valid_q;
  assign result_o.angle_deg           = out_q.angle_deg;
  assign result_o.orientation         = out_q.orientation;
  assign result_o.direction_undefined = out_q.direction_undefined;

endmodule
